>>> rtl/vln_pkg.sv
// ----------------------------------------------------------------------------
// vln_pkg
// Shared types, constants and single-precision helper functions for the
// vector length / normalize pipeline (round to nearest even, subnormals kept).
// ----------------------------------------------------------------------------
package vln_pkg;

  localparam logic [31:0] QNanDflt  = 32'hFFC0_0000;  // invalid operation result
  localparam logic [31:0] DivNan    = 32'h7FC0_0000;  // zero over zero
  localparam logic [31:0] PosInf    = 32'h7F80_0000;
  localparam logic [31:0] QuietBit  = 32'h0040_0000;
  localparam logic [31:0] GuessSub  = 32'h0080_0000;
  localparam logic [31:0] GuessAdd  = 32'h2000_0000;
  localparam logic [31:0] OneF      = 32'h3F80_0000;
  localparam logic [31:0] HalfF     = 32'h3F00_0000;
  localparam int          DivSteps  = 26;

  typedef logic signed [10:0] exp_t;

  // unrounded result: 1 + 23 fraction + guard + round + sticky
  typedef struct packed {
    logic        spec;
    logic [31:0] bits;
    logic        sgn;
    exp_t        exp;
    logic [26:0] man;
  } unr_t;

  typedef struct packed {
    logic        spec;
    logic [31:0] bits;
    logic        sgn;
    exp_t        exp;
    logic [47:0] prod;
  } mulp_t;

  typedef struct packed {
    logic        spec;
    logic [31:0] bits;
    logic        sgn;
    logic        sub;
    exp_t        exp;
    logic [26:0] big;
    logic [26:0] al;
  } addp_t;

  typedef struct packed {
    logic        spec;
    logic [31:0] bits;
    logic        sgn;
    exp_t        exp;
    logic [23:0] md;
    logic [24:0] rem;
    logic [25:0] q;
  } divi_t;

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  function automatic logic is_zero(input logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  function automatic logic [7:0] ef(input logic [31:0] x);
    return (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
  endfunction

  function automatic logic [23:0] mant(input logic [31:0] x);
    return {x[30:23] != 8'd0, x[22:0]};
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  function automatic logic [31:0] round_pack(input unr_t u);
    logic [4:0]  sh;
    logic [26:0] m;
    logic        stk;
    logic        up;
    logic [24:0] r;
    logic [30:0] tot;
    exp_t        amt;
    sh  = 5'd0;
    amt = exp_t'(1) - u.exp;
    if (u.spec) return u.bits;
    if (u.exp >= exp_t'(255)) return {u.sgn, PosInf[30:0]};
    if (u.exp < exp_t'(1)) sh = (amt > exp_t'(27)) ? 5'd27 : amt[4:0];
    m   = u.man >> sh;
    stk = |(u.man & ~(27'h7FF_FFFF << sh));
    up  = m[2] & (m[3] | m[1] | m[0] | stk);
    r   = {1'b0, m[26:3]} + 25'(up);
    if (u.exp >= exp_t'(1)) tot = {u.exp[7:0] - 8'd1, 23'd0} + 31'(r);
    else tot = 31'(r);
    return {u.sgn, tot};
  endfunction

  function automatic mulp_t mul_pre(input logic [31:0] a, input logic [31:0] b);
    mulp_t r;
    r.spec = 1'b1;
    r.bits = '0;
    r.sgn  = a[31] ^ b[31];
    r.exp  = exp_t'({3'b0, ef(a)}) + exp_t'({3'b0, ef(b)}) - exp_t'(126);
    r.prod = mant(a) * mant(b);
    if (is_nan(a)) r.bits = a | QuietBit;
    else if (is_nan(b)) r.bits = b | QuietBit;
    else if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) r.bits = QNanDflt;
    else if (is_inf(a) || is_inf(b)) r.bits = {r.sgn, PosInf[30:0]};
    else if (is_zero(a) || is_zero(b)) r.bits = {r.sgn, 31'd0};
    else r.spec = 1'b0;
    return r;
  endfunction

  function automatic unr_t mul_norm(input mulp_t p);
    unr_t        r;
    logic [5:0]  lz;
    logic [47:0] sh;
    lz     = lzc48(p.prod);
    sh     = p.prod << lz;
    r.spec = p.spec;
    r.bits = p.bits;
    r.sgn  = p.sgn;
    r.exp  = p.exp - exp_t'({5'b0, lz});
    r.man  = {sh[47:22], |sh[21:0]};
    return r;
  endfunction

  function automatic addp_t add_pre(input logic [31:0] a, input logic [31:0] b);
    addp_t       r;
    logic        swap;
    logic [31:0] x;
    logic [31:0] y;
    logic [7:0]  d;
    logic [26:0] sm;
    swap   = b[30:0] > a[30:0];
    x      = swap ? b : a;
    y      = swap ? a : b;
    d      = ef(x) - ef(y);
    sm     = {mant(y), 3'b0};
    r.sgn  = x[31];
    r.sub  = a[31] ^ b[31];
    r.exp  = exp_t'({3'b0, ef(x)});
    r.big  = {mant(x), 3'b0};
    if (d >= 8'd27) r.al = {26'd0, |sm};
    else r.al = (sm >> d) | {26'd0, |(sm & ~(27'h7FF_FFFF << d))};
    r.spec = 1'b1;
    r.bits = '0;
    if (is_nan(a)) r.bits = a | QuietBit;
    else if (is_nan(b)) r.bits = b | QuietBit;
    else if (is_inf(a) && is_inf(b) && r.sub) r.bits = QNanDflt;
    else if (is_inf(a)) r.bits = a;
    else if (is_inf(b)) r.bits = b;
    else r.spec = 1'b0;
    return r;
  endfunction

  function automatic unr_t add_norm(input addp_t p);
    unr_t        r;
    logic [27:0] sum;
    logic [5:0]  lz;
    sum    = p.sub ? ({1'b0, p.big} - {1'b0, p.al}) : ({1'b0, p.big} + {1'b0, p.al});
    lz     = lzc48({sum[26:0], 21'd0});
    r.spec = p.spec;
    r.bits = p.bits;
    r.sgn  = p.sgn;
    r.exp  = p.exp - exp_t'({5'b0, lz});
    r.man  = sum[26:0] << lz;
    if (!p.spec && sum == 28'd0) begin
      r.spec = 1'b1;
      r.bits = {p.sgn & ~p.sub, 31'd0};
    end else if (sum[27]) begin
      r.exp = p.exp + exp_t'(1);
      r.man = {sum[27:2], sum[1] | sum[0]};
    end
    return r;
  endfunction

  function automatic divi_t div_pre(input logic [31:0] n, input logic [31:0] d);
    divi_t       r;
    logic [5:0]  lzn;
    logic [5:0]  lzd;
    logic [23:0] mn;
    logic [23:0] md;
    lzn    = lzc48({mant(n), 24'd0});
    lzd    = lzc48({mant(d), 24'd0});
    mn     = mant(n) << lzn;
    md     = mant(d) << lzd;
    r.sgn  = n[31] ^ d[31];
    r.exp  = exp_t'({3'b0, ef(n)}) - exp_t'({5'b0, lzn}) - exp_t'({3'b0, ef(d)})
           + exp_t'({5'b0, lzd}) + exp_t'(127);
    r.md   = md;
    r.q    = '0;
    r.rem  = {1'b0, mn};
    if (mn < md) begin
      r.rem = {mn, 1'b0};
      r.exp = r.exp - exp_t'(1);
    end
    r.spec = 1'b1;
    r.bits = '0;
    if (is_zero(d)) begin
      if (is_nan(n)) r.bits = n | QuietBit;
      else if (is_zero(n)) r.bits = DivNan;
      else r.bits = {r.sgn, PosInf[30:0]};
    end else if (is_nan(n)) r.bits = n | QuietBit;
    else if (is_nan(d)) r.bits = d | QuietBit;
    else if (is_inf(n) && is_inf(d)) r.bits = QNanDflt;
    else if (is_inf(n)) r.bits = {r.sgn, PosInf[30:0]};
    else if (is_inf(d) || is_zero(n)) r.bits = {r.sgn, 31'd0};
    else r.spec = 1'b0;
    return r;
  endfunction

  function automatic divi_t div_step(input divi_t s);
    divi_t       r;
    logic        ge;
    logic [24:0] diff;
    r     = s;
    ge    = s.rem >= {1'b0, s.md};
    diff  = ge ? (s.rem - {1'b0, s.md}) : s.rem;
    r.rem = {diff[23:0], 1'b0};
    r.q   = {s.q[24:0], ge};
    return r;
  endfunction

  function automatic unr_t div_fin(input divi_t s);
    unr_t r;
    r.spec = s.spec;
    r.bits = s.bits;
    r.sgn  = s.sgn;
    r.exp  = s.exp;
    r.man  = {s.q, s.rem != 25'd0};
    return r;
  endfunction

endpackage

>>> rtl/vln_if.sv
// ----------------------------------------------------------------------------
// vln_if
// Valid/ready channels carrying the input vector word and the result word.
// ----------------------------------------------------------------------------
interface vln_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  vector_size;
  logic [31:0] comp_x;
  logic [31:0] comp_y;
  logic [31:0] comp_z;
  logic [31:0] comp_w;

  modport source (output valid, vector_size, comp_x, comp_y, comp_z, comp_w, input ready);
  modport sink   (input valid, vector_size, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

interface vln_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] length_bits;
  logic [31:0] unit_x;
  logic [31:0] unit_y;
  logic [31:0] unit_z;
  logic [31:0] unit_w;

  modport source (output valid, length_bits, unit_x, unit_y, unit_z, unit_w, input ready);
  modport sink   (input valid, length_bits, unit_x, unit_y, unit_z, unit_w, output ready);
endinterface

>>> rtl/vln_fmul.sv
// ----------------------------------------------------------------------------
// vln_fmul
// Three-stage single-precision multiplier, Lanes wide, with side data.
// ----------------------------------------------------------------------------
module vln_fmul import vln_pkg::*; #(
  parameter int Lanes = 1,
  parameter int SideW = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [Lanes-1:0][31:0]      a_i,
  input  logic [Lanes-1:0][31:0]      b_i,
  input  logic [SideW-1:0]            side_i,
  output logic                        valid_o,
  output logic [Lanes-1:0][31:0]      res_o,
  output logic [SideW-1:0]            side_o
);

  logic [2:0]               v_q;
  mulp_t                    s1_q [Lanes];
  unr_t                     s2_q [Lanes];
  logic [Lanes-1:0][31:0]   s3_q;
  logic [SideW-1:0]         sd1_q, sd2_q, sd3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < Lanes; l++) begin
        s1_q[l] <= mul_pre(a_i[l], b_i[l]);
        s2_q[l] <= mul_norm(s1_q[l]);
        s3_q[l] <= round_pack(s2_q[l]);
      end
      sd1_q <= side_i;
      sd2_q <= sd1_q;
      sd3_q <= sd2_q;
    end
  end

  assign valid_o = v_q[2];
  assign res_o   = s3_q;
  assign side_o  = sd3_q;

endmodule

>>> rtl/vln_fadd.sv
// ----------------------------------------------------------------------------
// vln_fadd
// Three-stage single-precision adder: align, add and normalize, round.
// ----------------------------------------------------------------------------
module vln_fadd import vln_pkg::*; #(
  parameter int SideW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [31:0]       a_i,
  input  logic [31:0]       b_i,
  input  logic [SideW-1:0]  side_i,
  output logic              valid_o,
  output logic [31:0]       res_o,
  output logic [SideW-1:0]  side_o
);

  logic [2:0]        v_q;
  addp_t             s1_q;
  unr_t              s2_q;
  logic [31:0]       s3_q;
  logic [SideW-1:0]  sd1_q, sd2_q, sd3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q  <= add_pre(a_i, b_i);
      s2_q  <= add_norm(s1_q);
      s3_q  <= round_pack(s2_q);
      sd1_q <= side_i;
      sd2_q <= sd1_q;
      sd3_q <= sd2_q;
    end
  end

  assign valid_o = v_q[2];
  assign res_o   = s3_q;
  assign side_o  = sd3_q;

endmodule

>>> rtl/vln_fdiv.sv
// ----------------------------------------------------------------------------
// vln_fdiv
// Pipelined single-precision divider: unpack, one quotient bit per stage,
// round. Zero divisors give signed infinity, or NaN for zero over zero or a NaN numerator.
// ----------------------------------------------------------------------------
module vln_fdiv import vln_pkg::*; #(
  parameter int SideW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [31:0]       num_i,
  input  logic [31:0]       den_i,
  input  logic [SideW-1:0]  side_i,
  output logic              valid_o,
  output logic [31:0]       res_o,
  output logic [SideW-1:0]  side_o
);

  logic [DivSteps+1:0]  v_q;
  divi_t                st_q [DivSteps+1];
  logic [SideW-1:0]     sd_q [DivSteps+1];
  logic [31:0]          res_q;
  logic [SideW-1:0]     sdo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DivSteps:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= div_pre(num_i, den_i);
      sd_q[0] <= side_i;
      for (int k = 1; k <= DivSteps; k++) begin
        st_q[k] <= div_step(st_q[k-1]);
        sd_q[k] <= sd_q[k-1];
      end
      res_q <= round_pack(div_fin(st_q[DivSteps]));
      sdo_q <= sd_q[DivSteps];
    end
  end

  assign valid_o = v_q[DivSteps+1];
  assign res_o   = res_q;
  assign side_o  = sdo_q;

endmodule

>>> rtl/vector_length_normalize.sv
// ----------------------------------------------------------------------------
// vector_length_normalize
// Approximate length (bit-trick guess plus one Newton step) and unit vector
// of a 2-, 3- or 4-component single-precision vector.
//
//   channel | dir | handshake     | word
//   in_i    | in  | valid / ready | vector_size, comp_x..comp_w
//   out_o   | out | valid / ready | length_bits, unit_x..unit_w
//
// One word per cycle sustained while the output buffer is not full; words
// pass through the two 28-stage dividers plus multiply and add stages.
// Reset clears all valid bits and the two-entry output buffer.
// The whole pipe holds while the output buffer is full; the buffer lets the
// pipe keep moving while a finished word waits to be taken.
// ----------------------------------------------------------------------------
module vector_length_normalize import vln_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  vln_in_if.sink     in_i,
  vln_out_if.source  out_o
);

  typedef struct packed {
    logic [2:0]        n;
    logic [3:0][31:0]  c;
  } base_t;

  typedef struct packed {
    base_t        b;
    logic [31:0]  sq2;
    logic [31:0]  sq3;
  } s1_t;

  typedef struct packed {
    base_t        b;
    logic [31:0]  sq3;
  } s2_t;

  typedef struct packed {
    base_t        b;
    logic [31:0]  v;
  } bv_t;

  typedef struct packed {
    logic [2:0]   n;
    logic [31:0]  len;
  } fin_t;

  typedef struct packed {
    logic [31:0]       len;
    logic [3:0][31:0]  unit;
  } result_t;

  logic              en;
  logic [2:0]        n;
  base_t             base_in;

  logic              sq_v;
  logic [3:0][31:0]  sq;
  base_t             sq_b;
  logic              a1_v, a2_v, a3_v, a4_v;
  logic [31:0]       dot1, dot2, dot3, nsum;
  s1_t               a1_s;
  s2_t               a2_s;
  base_t             a3_b, a4_b, h_b;
  logic [31:0]       tg, guess;
  logic              d1_v, d2_v, h_v, m_v;
  logic [31:0]       quo, len, rcp;
  bv_t               d1_s, d2_s;
  logic [3:0][31:0]  prod;
  fin_t              m_s;
  result_t           res;

  result_t           buf_q [2];
  logic              wp_q, rp_q;
  logic [1:0]        cnt_q;
  logic              push, pop;

  assign en       = (cnt_q != 2'd2);
  assign in_i.ready = en;

  always_comb begin
    if (in_i.vector_size < 3'd2) n = 3'd2;
    else if (in_i.vector_size > 3'd4) n = 3'd4;
    else n = in_i.vector_size;
  end

  assign base_in.n = n;
  assign base_in.c = {(n == 3'd4) ? in_i.comp_w : 32'd0,
                      (n >= 3'd3) ? in_i.comp_z : 32'd0,
                      in_i.comp_y, in_i.comp_x};

  vln_fmul #(.Lanes(4), .SideW($bits(base_t))) u_sq (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid & en),
    .a_i(base_in.c), .b_i(base_in.c), .side_i(base_in),
    .valid_o(sq_v), .res_o(sq), .side_o(sq_b)
  );

  vln_fadd #(.SideW($bits(s1_t))) u_add1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_v),
    .a_i(sq[0]), .b_i(sq[1]), .side_i({sq_b, sq[2], sq[3]}),
    .valid_o(a1_v), .res_o(dot1), .side_o(a1_s)
  );

  vln_fadd #(.SideW($bits(s2_t))) u_add2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(a1_v),
    .a_i(dot1), .b_i(a1_s.sq2), .side_i({a1_s.b, a1_s.sq3}),
    .valid_o(a2_v), .res_o(dot2), .side_o(a2_s)
  );

  vln_fadd #(.SideW($bits(base_t))) u_add3 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(a2_v),
    .a_i(dot2), .b_i(a2_s.sq3), .side_i(a2_s.b),
    .valid_o(a3_v), .res_o(dot3), .side_o(a3_b)
  );

  // root guess from the raw bits, arithmetic shift
  assign tg    = dot3 - GuessSub;
  assign guess = {tg[31], tg[31:1]} + GuessAdd;

  vln_fdiv #(.SideW($bits(bv_t))) u_div1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(a3_v),
    .num_i(dot3), .den_i(guess), .side_i({a3_b, guess}),
    .valid_o(d1_v), .res_o(quo), .side_o(d1_s)
  );

  vln_fadd #(.SideW($bits(base_t))) u_add4 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d1_v),
    .a_i(quo), .b_i(d1_s.v), .side_i(d1_s.b),
    .valid_o(a4_v), .res_o(nsum), .side_o(a4_b)
  );

  vln_fmul #(.Lanes(1), .SideW($bits(base_t))) u_half (
    .clk_i, .rst_ni, .en_i(en), .valid_i(a4_v),
    .a_i(nsum), .b_i(HalfF), .side_i(a4_b),
    .valid_o(h_v), .res_o(len), .side_o(h_b)
  );

  vln_fdiv #(.SideW($bits(bv_t))) u_div2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(h_v),
    .num_i(OneF), .den_i(len), .side_i({h_b, len}),
    .valid_o(d2_v), .res_o(rcp), .side_o(d2_s)
  );

  vln_fmul #(.Lanes(4), .SideW($bits(fin_t))) u_scale (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d2_v),
    .a_i(d2_s.b.c), .b_i({4{rcp}}), .side_i({d2_s.b.n, d2_s.v}),
    .valid_o(m_v), .res_o(prod), .side_o(m_s)
  );

  assign res.len     = m_s.len;
  assign res.unit[0] = prod[0];
  assign res.unit[1] = prod[1];
  assign res.unit[2] = (m_s.n >= 3'd3) ? prod[2] : 32'd0;
  assign res.unit[3] = (m_s.n == 3'd4) ? prod[3] : 32'd0;

  // two-entry output buffer
  assign push = en & m_v;
  assign pop  = out_o.valid & out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= res;
  end

  assign out_o.valid       = (cnt_q != 2'd0);
  assign out_o.length_bits = buf_q[rp_q].len;
  assign out_o.unit_x      = buf_q[rp_q].unit[0];
  assign out_o.unit_y      = buf_q[rp_q].unit[1];
  assign out_o.unit_z      = buf_q[rp_q].unit[2];
  assign out_o.unit_w      = buf_q[rp_q].unit[3];

endmodule
